### hdl/zlr_pkg.sv
// Package with shared constants and types for the zone lightness remap block.
package zlr_pkg;
    localparam int MAX_ZONES_DEF = 24;
    localparam int FRAC_BITS_DEF = 15;
    localparam int NUM_WORDS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_0 = 3'd1;
    localparam logic [15:0] UNSET_POINT = 16'hFFFF;

    typedef struct packed {
        logic build_start;
        logic pix_load;
        logic scan_step;
    } t_cmd;

    typedef struct packed {
        logic build_done;
        logic scan_done;
    } t_status;
endpackage

### hdl/zlr_if.sv
// Valid and ready interfaces for the pixel, result and configuration channels.
interface zlr_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] light_in;
    logic signed [15:0] chroma_a_in;
    logic signed [15:0] chroma_b_in;
    logic        frame_end_in;
    modport source (output valid, light_in, chroma_a_in, chroma_b_in, frame_end_in,
                    input ready);
    modport sink (input valid, light_in, chroma_a_in, chroma_b_in, frame_end_in,
                  output ready);
endinterface

interface zlr_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] light_out;
    logic signed [15:0] chroma_a_out;
    logic signed [15:0] chroma_b_out;
    logic [4:0]  zone_number;
    logic        frame_end_out;
    modport source (output valid, light_out, chroma_a_out, chroma_b_out, zone_number,
                    frame_end_out, input ready);
    modport sink (input valid, light_out, chroma_a_out, chroma_b_out, zone_number,
                  frame_end_out, output ready);
endinterface

interface zlr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/zlr_ctrl.sv
// Controller state machine that sequences map builds and pixel processing.
module zlr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_pix_fire,
    input  logic              i_res_free,
    input  zlr_pkg::t_status  i_status,
    output zlr_pkg::t_cmd     o_cmd,
    output logic              o_cfg_ready,
    output logic              o_pix_ready,
    output logic              o_res_load
);
    localparam logic [1:0] S_BUILD = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_start, n_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BUILD;
            r_start <= 1'b1;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        o_cmd = '0;
        o_cfg_ready = 1'b0;
        o_pix_ready = 1'b0;
        o_res_load = 1'b0;
        unique case (r_state)
            S_BUILD: begin
                o_cmd.build_start = r_start;
                if (!r_start && i_status.build_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_pix_ready = !i_cfg_wr;
                o_cmd.pix_load = i_pix_fire;
                if (i_pix_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_BUILD;
        endcase
        if (i_cfg_wr) begin
            n_state = S_BUILD;
            n_start = 1'b1;
        end
    end
endmodule

### hdl/zlr_datapath.sv
// Datapath with configuration registers, zone map builder and pixel remap unit.
module zlr_datapath #(
    parameter int MAX_ZONES = zlr_pkg::MAX_ZONES_DEF,
    parameter int FRAC_BITS = zlr_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  zlr_pkg::t_cmd     i_cmd,
    output zlr_pkg::t_status  o_status,
    input  logic [15:0]       i_light,
    output logic [15:0]       o_light,
    output logic [4:0]        o_zone
);
    localparam int KW = $clog2(MAX_ZONES);
    localparam int UNITY = 1 << FRAC_BITS;

    logic [4:0]  r_count;
    logic [63:0] r_words [zlr_pkg::NUM_WORDS];
    logic [15:0] r_map [MAX_ZONES];

    logic [4:0] n_act;
    always_comb begin
        n_act = r_count;
        if (r_count < 5'd4) n_act = 5'd4;
        if (32'(r_count) > MAX_ZONES) n_act = 5'(MAX_ZONES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd10;
            for (int w = 0; w < zlr_pkg::NUM_WORDS; w++) r_words[w] <= '1;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == zlr_pkg::REG_ZONE_COUNT) r_count <= i_cfg_data[4:0];
            else if (32'(i_cfg_index) <= zlr_pkg::NUM_WORDS)
                r_words[i_cfg_index - zlr_pkg::REG_POINTS_0] <= i_cfg_data;
        end
    end

    // Map builder: walk k forward; on each set point, fill the gap behind it.
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_WALK = 2'd1;
    localparam logic [1:0] B_FILL = 2'd2;
    localparam logic [1:0] B_DIV  = 2'd3;
    logic [1:0]  r_bst;
    logic [5:0]  r_k, r_prev, r_l;
    logic [15:0] r_left;
    logic signed [17:0] r_diff;
    logic signed [23:0] r_num;
    logic [4:0]  r_den;
    logic signed [23:0] r_quo;
    logic [4:0]  r_dcnt;
    logic signed [23:0] r_rem;
    logic [15:0] s_pt, s_val;
    logic        s_interior;
    logic [23:0] s_q;
    logic        r_wq;

    always_comb begin
        s_pt = zlr_pkg::UNSET_POINT;
        if (r_k < 6'd24) s_pt = r_words[r_k[4:2]][16*r_k[1:0] +: 16];
        s_interior = (r_k != 6'd0) && (r_k != {1'b0, n_act} - 6'd1);
        if (r_k == 6'd0) s_val = 16'd0;
        else if (!s_interior) s_val = 16'(UNITY);
        else s_val = s_pt;
    end

    logic signed [23:0] s_tr;
    always_comb s_tr = {r_rem[22:0], r_num[23 - 32'(r_dcnt)]};

    always_comb s_q = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst <= B_IDLE;
        end else begin
            unique case (r_bst)
                B_IDLE: if (i_cmd.build_start) begin
                    r_bst <= B_WALK;
                    r_k <= '0;
                    r_prev <= '0;
                    for (int z = 0; z < MAX_ZONES; z++) r_map[z] <= '0;
                end
                B_WALK: begin
                    if (r_k == {1'b0, n_act}) r_bst <= B_IDLE;
                    else if (s_interior && s_pt == zlr_pkg::UNSET_POINT) r_k <= r_k + 6'd1;
                    else begin
                        r_map[r_k[KW-1:0]] <= s_val;
                        r_left <= r_map[r_prev[KW-1:0]];
                        r_diff <= $signed({2'b0, s_val}) -
                                  $signed({2'b0, r_map[r_prev[KW-1:0]]});
                        r_den <= 5'(r_k - r_prev);
                        r_l <= 6'd1;
                        r_bst <= B_FILL;
                    end
                end
                B_FILL: begin
                    if (r_l >= {1'b0, r_den}) begin
                        r_prev <= r_k;
                        r_k <= r_k + 6'd1;
                        r_bst <= B_WALK;
                    end else begin
                        // Offset by a multiple of den keeps the dividend positive.
                        r_num <= 24'(r_diff * $signed({18'b0, r_l})) +
                                 24'({r_den[4:1]}) + 24'(32'(r_den) * 65536);
                        r_dcnt <= '0;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bst <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (s_tr >= $signed({19'b0, r_den})) begin
                        r_rem <= s_tr - $signed({19'b0, r_den});
                        r_quo <= {r_quo[22:0], 1'b1};
                    end else begin
                        r_rem <= s_tr;
                        r_quo <= {r_quo[22:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd23) begin
                        r_bst <= B_FILL;
                        r_l <= r_l + 6'd1;
                    end
                end
                default: r_bst <= B_IDLE;
            endcase
            if (r_wq) r_map[KW'(r_prev + r_l - 6'd1)] <=
                16'(32'(r_left) + 32'(s_q) - 65536);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wq <= 1'b0;
        else r_wq <= (r_bst == B_DIV && r_dcnt == 5'd23);
    end

    assign o_status.build_done = (r_bst == B_IDLE) && !i_cmd.build_start && !r_wq;

    // Pixel: remap steps first, then zone search one boundary a cycle.
    logic [15:0] r_lt;
    logic [20:0] r_prod;
    logic [4:0]  r_rz, r_sk;
    logic [2:0]  r_ph;
    logic        r_found;
    logic signed [17:0] r_span;
    logic [15:0] r_t;
    logic signed [34:0] r_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0;
        end else if (i_cmd.pix_load) begin
            r_lt <= (i_light > 16'(UNITY)) ? 16'(UNITY) : i_light;
            r_ph <= 3'd1;
        end else if (i_cmd.scan_step) begin
            unique case (r_ph)
                3'd1: begin
                    r_prod <= 21'(r_lt) * 21'(n_act - 5'd1);
                    r_ph <= 3'd2;
                end
                3'd2: begin
                    r_rz <= (5'(r_prod >> FRAC_BITS) > n_act - 5'd2) ? n_act - 5'd2
                            : 5'(r_prod >> FRAC_BITS);
                    r_ph <= 3'd3;
                end
                3'd3: begin
                    r_t <= 16'(r_prod - 21'(32'(r_rz) << FRAC_BITS));
                    r_span <= $signed({2'b0, r_map[r_rz + 5'd1]}) -
                              $signed({2'b0, r_map[r_rz]});
                    r_ph <= 3'd4;
                end
                3'd4: begin
                    r_mul <= $signed({19'b0, r_t}) * r_span + 35'(UNITY / 2);
                    r_sk <= '0;
                    r_found <= 1'b0;
                    o_zone <= '0;
                    r_ph <= 3'd5;
                end
                3'd5: begin
                    if (!r_found && r_map[r_sk] <= r_lt && r_map[r_sk + 5'd1] >= r_lt) begin
                        r_found <= 1'b1;
                        o_zone <= r_sk;
                    end
                    r_sk <= r_sk + 5'd1;
                    if (r_sk == n_act - 5'd2) begin
                        r_ph <= 3'd6;
                        begin
                            logic signed [35:0] v;
                            v = $signed({20'b0, r_map[r_rz]}) + 36'(r_mul >>> FRAC_BITS);
                            if (v < 0) o_light <= '0;
                            else if (v > UNITY) o_light <= 16'(UNITY);
                            else o_light <= 16'(v);
                        end
                    end
                end
                default: r_ph <= 3'd0;
            endcase
        end
    end
    assign o_status.scan_done = (r_ph == 3'd6);
endmodule

### hdl/zone_lightness_remap_top.sv
// Zone lightness remap top level: map build, controller and result register.
// A new pixel word is accepted only after the previous result is loaded into the result register;
// the zone search takes a boundary a cycle.
// After reset and after each configuration write the zone map is rebuilt with a
// serial divider, while no pixel or configuration word is accepted.
// Reset is synchronous and active low and restores the register defaults.
module zone_lightness_remap_top #(
    parameter int MAX_ZONES = zlr_pkg::MAX_ZONES_DEF,
    parameter int FRAC_BITS = zlr_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    zlr_cfg_if.sink    cfg,
    zlr_pix_if.sink    pix,
    zlr_res_if.source  res
);
    zlr_pkg::t_cmd    s_cmd;
    zlr_pkg::t_status s_status;
    logic s_cfg_wr, s_pix_fire, s_res_load;
    logic [15:0] s_light;
    logic [4:0]  s_zone;
    logic signed [15:0] r_a, r_b;
    logic r_fe, r_valid;

    assign s_cfg_wr = cfg.valid && cfg.ready;
    assign s_pix_fire = pix.valid && pix.ready;

    zlr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr(s_cfg_wr),
        .i_pix_fire(s_pix_fire), .i_res_free(!r_valid || res.ready),
        .i_status(s_status), .o_cmd(s_cmd), .o_cfg_ready(cfg.ready),
        .o_pix_ready(pix.ready), .o_res_load(s_res_load)
    );

    zlr_datapath #(.MAX_ZONES(MAX_ZONES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr(s_cfg_wr),
        .i_cfg_index(cfg.index), .i_cfg_data(cfg.data), .i_cmd(s_cmd),
        .o_status(s_status), .i_light(pix.light_in), .o_light(s_light), .o_zone(s_zone)
    );

    always_ff @(posedge i_clk) begin
        if (s_pix_fire) begin
            r_a <= pix.chroma_a_in;
            r_b <= pix.chroma_b_in;
            r_fe <= pix.frame_end_in;
        end
        if (s_res_load) begin
            res.light_out <= s_light;
            res.zone_number <= s_zone;
            res.chroma_a_out <= r_a;
            res.chroma_b_out <= r_b;
            res.frame_end_out <= r_fe;
        end
        if (!i_rst_n) r_valid <= 1'b0;
        else if (s_res_load) r_valid <= 1'b1;
        else if (res.ready) r_valid <= 1'b0;
    end
    assign res.valid = r_valid;
endmodule

### tb/sv/tb_zone_lightness_remap_top.sv
// Self-checking testbench for the zone lightness remap block with a built-in tone curve predictor.
module tb_zone_lightness_remap_top;
    typedef struct packed {
        logic [15:0] light;
        logic [15:0] chroma_a;
        logic [15:0] chroma_b;
        logic        frame_end;
    } t_pixel;

    typedef struct packed {
        logic [15:0] light;
        logic [15:0] chroma_a;
        logic [15:0] chroma_b;
        logic [4:0]  zone;
        logic        frame_end;
    } t_result;

    localparam int UNITY = 32768;

    logic i_clk;
    logic i_rst_n;
    int   fail_count = 0;

    zlr_cfg_if cfg_ch ();
    zlr_pix_if pix_ch ();
    zlr_res_if res_ch ();

    zone_lightness_remap_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_ch.sink),
        .pix     (pix_ch.sink),
        .res     (res_ch.source)
    );

    logic [4:0]  zone_count_reg;
    logic [63:0] point_words[zlr_pkg::NUM_WORDS];
    int          curve_map[zlr_pkg::MAX_ZONES_DEF];

    t_pixel  pending_pixels[$];
    t_result expected_results[$];
    int      burst_left = 1;
    int      gap_left = 0;
    int      stall_phase = 0;
    int      pix_taken = 0;
    int      pix_shown = 0;

    function automatic int floor_divide(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return int'(q);
    endfunction

    function automatic int boundary_count();
        int n;
        n = zone_count_reg;
        if (n < 4) n = 4;
        if (n > zlr_pkg::MAX_ZONES_DEF) n = zlr_pkg::MAX_ZONES_DEF;
        return n;
    endfunction

    function automatic void rebuild_curve();
        int n;
        int steps;
        int prev;
        int pt;
        int left;
        int diff;
        n = boundary_count();
        steps = 0;
        prev = 0;
        foreach (curve_map[k]) curve_map[k] = 0;
        for (int k = 0; k < n; k++) begin
            pt = (k / 4 < zlr_pkg::NUM_WORDS) ? int'(point_words[k / 4][16 * (k % 4) +: 16])
                                              : int'(zlr_pkg::UNSET_POINT);
            if (k > 0 && k < n - 1 && pt == int'(zlr_pkg::UNSET_POINT)) begin
                steps++;
                continue;
            end
            if (k == 0) curve_map[k] = 0;
            else if (k == n - 1) curve_map[k] = UNITY;
            else curve_map[k] = pt;
            left = curve_map[prev];
            diff = curve_map[k] - left;
            for (int l = 1; l <= steps; l++)
                curve_map[prev + l] = (left + floor_divide(longint'(diff) * l + (steps + 1) / 2,
                                                           steps + 1)) & 16'hFFFF;
            prev = k;
            steps = 0;
        end
    endfunction

    function automatic t_result remap_pixel(t_pixel p);
        t_result r;
        int n;
        longint lt;
        longint rz;
        longint t;
        longint span;
        longint v;
        n = boundary_count();
        lt = p.light;
        if (lt > UNITY) lt = UNITY;
        rz = (lt * (n - 1)) >>> 15;
        if (rz > n - 2) rz = n - 2;
        t = lt * (n - 1) - rz * UNITY;
        span = curve_map[rz + 1] - curve_map[rz];
        v = curve_map[rz] + floor_divide(t * span + UNITY / 2, UNITY);
        if (v < 0) v = 0;
        if (v > UNITY) v = UNITY;
        r.light = v[15:0];
        r.chroma_a = p.chroma_a;
        r.chroma_b = p.chroma_b;
        r.frame_end = p.frame_end;
        r.zone = 0;
        for (int k = 0; k < n - 1; k++) begin
            if (curve_map[k] <= lt && curve_map[k + 1] >= lt) begin
                r.zone = k[4:0];
                break;
            end
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Pixel driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (pix_ch.valid && pix_shown == pix_taken) begin
        end else if (gap_left > 0) begin
            pix_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_pixels.size() > 0) begin
            pix_ch.valid <= 1'b1;
            {pix_ch.light_in, pix_ch.chroma_a_in, pix_ch.chroma_b_in, pix_ch.frame_end_in}
                <= pending_pixels[0];
            pix_shown <= pix_taken;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            pix_ch.valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            expected_results.push_back(remap_pixel(pending_pixels.pop_front()));
            pix_taken <= pix_taken + 1;
        end
    end

    // Receiver stalls on a slowly drifting duty pattern.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else if (stall_phase[9]) res_ch.ready <= 1'b1;
        else res_ch.ready <= ($urandom_range(0, 99) < 20 + (stall_phase[8:6] * 10));
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word");
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (res_ch.light_out !== exp_r.light) begin
                    $error("light_out expected %0d actual %0d", exp_r.light, res_ch.light_out);
                    fail_count++;
                end
                if (res_ch.chroma_a_out !== exp_r.chroma_a) begin
                    $error("chroma_a_out expected %0h actual %0h", exp_r.chroma_a,
                           res_ch.chroma_a_out);
                    fail_count++;
                end
                if (res_ch.chroma_b_out !== exp_r.chroma_b) begin
                    $error("chroma_b_out expected %0h actual %0h", exp_r.chroma_b,
                           res_ch.chroma_b_out);
                    fail_count++;
                end
                if (res_ch.zone_number !== exp_r.zone) begin
                    $error("zone_number expected %0d actual %0d", exp_r.zone, res_ch.zone_number);
                    fail_count++;
                end
                if (res_ch.frame_end_out !== exp_r.frame_end) begin
                    $error("frame_end_out expected %0b actual %0b", exp_r.frame_end,
                           res_ch.frame_end_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_register(input logic [zlr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == zlr_pkg::REG_ZONE_COUNT) zone_count_reg = value[4:0];
        else point_words[idx - zlr_pkg::REG_POINTS_0] = value;
        rebuild_curve();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_light();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] random_point();
        case ($urandom_range(0, 7))
            0, 1, 2: return zlr_pkg::UNSET_POINT;
            3: return 16'($urandom_range(32769, 16'hFFFE));
            4: return 16'd0;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic queue_pixel(input logic [15:0] lt);
        t_pixel p;
        p.light = lt;
        p.chroma_a = 16'($urandom);
        p.chroma_b = 16'($urandom);
        p.frame_end = $urandom_range(0, 15) == 0;
        pending_pixels.push_back(p);
    endtask

    initial begin
        logic [63:0] w;
        int counts[7] = '{4, 24, 0, 31, 10, 2, 17};
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        zone_count_reg = 5'd10;
        foreach (point_words[i]) point_words[i] = '1;
        rebuild_curve();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default curve: a lightness ramp, extremes of lightness and chroma, frame end marks.
        foreach (counts[i]) queue_pixel(16'(i * 5461));
        pending_pixels.push_back('{16'd0, 16'h8000, 16'h7FFF, 1'b1});
        pending_pixels.push_back('{16'd32768, 16'h7FFF, 16'h8000, 1'b0});
        pending_pixels.push_back('{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1});
        pending_pixels.push_back('{16'd32769, 16'h0000, 16'hFFFF, 1'b0});
        wait_drained();

        // Non-monotonic curve with points above one, then random settings.
        write_register(zlr_pkg::REG_ZONE_COUNT, 64'd6);
        write_register(zlr_pkg::REG_POINTS_0, {16'd1000, 16'hFFFE, 16'hFFFF, 16'h1234});
        foreach (counts[i]) queue_pixel(16'(i * 5461));
        queue_pixel(16'd32768);
        queue_pixel(16'd40000);
        wait_drained();

        for (int phase = 0; phase < 16; phase++) begin
            write_register(zlr_pkg::REG_ZONE_COUNT,
                           (phase < 7) ? 64'(counts[phase]) : 64'($urandom_range(0, 31)));
            for (int wi = 1; wi <= zlr_pkg::NUM_WORDS; wi++) begin
                if (phase == 0) w = '0;
                else if (phase == 1) w = '1;
                else w = {random_point(), random_point(), random_point(), random_point()};
                write_register(wi[zlr_pkg::CFG_IDX_W-1:0], w);
            end
            for (int i = 0; i < 100; i++) queue_pixel(random_light());
            wait_drained();
        end
        if (fail_count == 0) $display("** zone_lightness_remap_top: PASSED **");
        else $display("** zone_lightness_remap_top: FAILED **");
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("** zone_lightness_remap_top: FAILED **");
        $finish;
    end
endmodule
